// ===== rtl/mtr_pkg.sv =====
// ----------------------------------------------------------------------------
// mtr_pkg
// Types, constants and word functions shared by the MT19937 generator.
// ----------------------------------------------------------------------------
package mtr_pkg;

  localparam int unsigned STATE_WORDS = 624;
  localparam int unsigned SHIFT_DIST  = 397;
  localparam int unsigned WORD_W      = 32;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t INIT_MULT    = 32'd1812433253;
  localparam word_t TWIST_XOR    = 32'h9908_B0DF;
  localparam word_t TEMPER_B     = 32'h9D2C_5680;
  localparam word_t TEMPER_C     = 32'hEFC6_0000;
  localparam word_t UPPER_MASK   = 32'h8000_0000;
  localparam word_t LOWER_MASK   = 32'h7FFF_FFFF;
  localparam word_t DEFAULT_SEED = 32'd5489;

  typedef enum logic {
    ST_SEED,
    ST_RUN
  } state_e;

  typedef enum logic {
    OP_SEED = 1'b0,
    OP_GEN  = 1'b1
  } op_e;

  typedef struct packed {
    logic  en;
    word_t word;
  } shift_t;

  function automatic word_t twist_word(word_t head, word_t nxt, word_t mid);
    word_t y;
    word_t ya;
    y  = (head & UPPER_MASK) | (nxt & LOWER_MASK);
    ya = y >> 1;
    if (y[0]) begin
      ya = ya ^ TWIST_XOR;
    end
    return mid ^ ya;
  endfunction

  function automatic word_t temper(word_t w);
    word_t y;
    y = w;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t seed_step(word_t prev, word_t idx);
    word_t m;
    m = prev ^ (prev >> 30);
    return (m * INIT_MULT) + idx;
  endfunction

endpackage

// ===== rtl/mtr_if.sv =====
// ----------------------------------------------------------------------------
// mtr_in_if / mtr_out_if
// Valid/ready channels for command items and random word items.
// ----------------------------------------------------------------------------
interface mtr_in_if;
  logic               valid;
  logic               ready;
  logic               op;
  mtr_pkg::word_t     seed;

  modport source (output valid, output op, output seed, input ready);
  modport sink   (input valid, input op, input seed, output ready);
endinterface

interface mtr_out_if;
  logic               valid;
  logic               ready;
  mtr_pkg::word_t     random_value;

  modport source (output valid, output random_value, input ready);
  modport sink   (input valid, input random_value, output ready);
endinterface

// ===== rtl/mersenne_twister_rng_unit.sv =====
// ----------------------------------------------------------------------------
// mersenne_twister_rng_unit
// MT19937 generator built as a shift line of state-word cells.
//
//   channel  dir  fields                     role
//   in_i     in   op (1), seed (32)          0: reseed, 1: next word
//   out_o    out  random_value (32)          tempered word, one per op 1
//
// In a generate item, the head, next and middle taps form the new word,
// which shifts in at the tail while its tempered value is registered. A
// reseed, and reset with seed 5489, fill the line one word a cycle through
// the seeding multiplier, with in_i.ready low until the line is full.
// in_i.ready is high while running and the output register is free or taken.
// ----------------------------------------------------------------------------
module mersenne_twister_rng_unit #(
  parameter int unsigned STATE_WORDS = mtr_pkg::STATE_WORDS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  mtr_in_if.sink    in_i,
  mtr_out_if.source out_o
);

  mtr_pkg::word_t  cell_q [STATE_WORDS];
  mtr_pkg::shift_t shift;

  for (genvar g = 0; g < STATE_WORDS; g++) begin : g_cell
    mtr_pkg::word_t cell_d;
    if (g == STATE_WORDS - 1) begin : g_tail
      assign cell_d = shift.word;
    end else begin : g_body
      assign cell_d = cell_q[g+1];
    end
    mtr_cell u_cell (
      .clk_i (clk_i),
      .en_i  (shift.en),
      .d_i   (cell_d),
      .q_o   (cell_q[g])
    );
  end

  mtr_ctrl #(
    .STATE_WORDS (STATE_WORDS)
  ) u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_i),
    .out_o   (out_o),
    .head_i  (cell_q[0]),
    .next_i  (cell_q[1]),
    .mid_i   (cell_q[mtr_pkg::SHIFT_DIST]),
    .tail_i  (cell_q[STATE_WORDS-1]),
    .shift_o (shift)
  );

endmodule

// ===== rtl/mtr_cell.sv =====
// ----------------------------------------------------------------------------
// mtr_cell
// One state word of the generator; takes its neighbour's word, or at the tail the new word, on a shift.
// ----------------------------------------------------------------------------
module mtr_cell (
  input  logic           clk_i,
  input  logic           en_i,
  input  mtr_pkg::word_t d_i,
  output mtr_pkg::word_t q_o
);

  mtr_pkg::word_t word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      word_q <= d_i;
    end
  end

  assign q_o = word_q;

endmodule

// ===== rtl/mtr_ctrl.sv =====
// ----------------------------------------------------------------------------
// mtr_ctrl
// Sequencer for seeding and twisting, handshakes and the output register.
// ----------------------------------------------------------------------------
module mtr_ctrl #(
  parameter int unsigned STATE_WORDS = mtr_pkg::STATE_WORDS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  mtr_in_if.sink           in_i,
  mtr_out_if.source        out_o,
  input  mtr_pkg::word_t   head_i,
  input  mtr_pkg::word_t   next_i,
  input  mtr_pkg::word_t   mid_i,
  input  mtr_pkg::word_t   tail_i,
  output mtr_pkg::shift_t  shift_o
);

  localparam int unsigned IdxW = $clog2(STATE_WORDS);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(STATE_WORDS - 1);

  mtr_pkg::state_e  state_q, state_d;
  logic [IdxW-1:0]  cnt_q, cnt_d;
  mtr_pkg::word_t   seed_q, seed_d;
  logic             out_valid_q, out_valid_d;
  mtr_pkg::word_t   out_data_q, out_data_d;

  logic             in_ready;
  logic             in_fire;
  logic             gen_fire;
  logic             seed_fire;
  mtr_pkg::word_t   twist_w;
  mtr_pkg::word_t   seed_w;

  assign in_ready  = (state_q == mtr_pkg::ST_RUN) && (!out_valid_q || out_o.ready);
  assign in_fire   = in_i.valid && in_ready;
  assign gen_fire  = in_fire && (mtr_pkg::op_e'(in_i.op) == mtr_pkg::OP_GEN);
  assign seed_fire = in_fire && (mtr_pkg::op_e'(in_i.op) == mtr_pkg::OP_SEED);

  assign twist_w = mtr_pkg::twist_word(head_i, next_i, mid_i);
  assign seed_w  = (cnt_q == '0) ? seed_q
                 : mtr_pkg::seed_step(tail_i, mtr_pkg::WORD_W'(cnt_q));

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    seed_d        = seed_q;
    shift_o.en    = 1'b0;
    shift_o.word  = twist_w;
    case (state_q)
      mtr_pkg::ST_SEED: begin
        shift_o.en   = 1'b1;
        shift_o.word = seed_w;
        cnt_d        = cnt_q + 1'b1;
        if (cnt_q == LastIdx) begin
          cnt_d   = '0;
          state_d = mtr_pkg::ST_RUN;
        end
      end
      mtr_pkg::ST_RUN: begin
        shift_o.en = gen_fire;
        if (seed_fire) begin
          state_d = mtr_pkg::ST_SEED;
          cnt_d   = '0;
          seed_d  = in_i.seed;
        end
      end
      default: begin
        state_d = mtr_pkg::ST_SEED;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (gen_fire) begin
      out_valid_d = 1'b1;
      out_data_d  = mtr_pkg::temper(twist_w);
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mtr_pkg::ST_SEED;
      cnt_q       <= '0;
      seed_q      <= mtr_pkg::DEFAULT_SEED;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      seed_q      <= seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign in_i.ready         = in_ready;
  assign out_o.valid        = out_valid_q;
  assign out_o.random_value = out_data_q;

  a_no_accept_while_seeding: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mtr_pkg::ST_SEED) |-> !in_ready)
    else $error("item accepted during seeding");

  a_gen_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_fire |=> (out_valid_q && (out_data_q == $past(mtr_pkg::temper(twist_w)))))
    else $error("generate item did not load the output register");

  a_seed_starts_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_fire |=> ((state_q == mtr_pkg::ST_SEED) && (cnt_q == '0)))
    else $error("seed item did not start a fill");

  a_seed_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_fire |=> (out_valid_q == $past(out_valid_q && !out_o.ready)))
    else $error("seed item changed the result stream");

  a_fill_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == mtr_pkg::ST_SEED) && (cnt_q == LastIdx)) |=> (state_q == mtr_pkg::ST_RUN))
    else $error("fill overran the state length");

endmodule
